FILE: hw/rtl/mavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared widths, defaults, the window clamp and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package mavg_pkg;

   localparam int SAMPLE_W           = 16;
   localparam int WIN_W              = 6;
   localparam int MAX_WINDOW_DEFAULT = 32;
   localparam int WINDOW_RESET       = 16;

   // Saturate a written window length into 1 .. max_w.
   function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] v,
                                                    input int unsigned max_w);
      logic [WIN_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = WIN_W'(1);
      end else if (32'(v) > max_w) begin
         r = WIN_W'(max_w);
      end
      return r;
   endfunction

   typedef struct packed {
      logic cfg_write;   // take a new window length, restart the window
      logic capture;     // latch sample, read the entry it replaces
      logic update;      // write entry, update running sum, advance position
      logic div_load;    // start a division of the running sum
      logic div_step;    // one quotient bit
      logic out_load;    // move the quotient into the result register
   } mavg_cmd_type;

   typedef struct packed {
      logic div_last;    // the current step yields the last quotient bit
   } mavg_sts_type;

endpackage

FILE: hw/rtl/mavg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter controller
// Sequences capture, window update, division and result hand-off.
// ----------------------------------------------------------------------------
module mavg_ctrl
   import mavg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  mavg_sts_type sts,
   output mavg_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Hold both input sides off while reset is applied.
   assign csr_ready  = ~reset;
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      cmd.cfg_write = csr_valid & csr_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.update = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/mavg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter datapath
// Sample window memory, running sum and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module mavg_datapath
   import mavg_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  mavg_cmd_type               cmd,
   output mavg_sts_type               sts,
   input  logic [WIN_W-1:0]           csr_wdata,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic signed [SAMPLE_W-1:0] average
);

   localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(SUM_W);

   logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] old_entry;
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;

   logic [WIN_W-1:0]       window_ff;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   wrapped_ff;
   logic                   pos_wrap;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   logic [SUM_W-1:0] dvd_ff, dvd_in;
   logic [WIN_W-1:0] rem_ff, rem_in;
   logic [WIN_W:0]   trial;
   logic             ge;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0] quot_signed;

   // Entries not yet written since the last restart read as zero: writes go
   // in order from position zero, so only after the first wrap is the old
   // entry real.
   assign old_entry = wrapped_ff ? rd_ff : '0;
   assign sum_in    = sum_ff + SUM_W'(sample_ff) - SUM_W'(old_entry);
   assign pos_wrap  = (int'(pos_ff) + 1 >= int'(window_ff));
   assign pos_in    = pos_wrap ? '0 : pos_ff + 1'b1;

   // Restoring division, one quotient bit a cycle; quotient shifts into dvd.
   assign trial  = {rem_ff, dvd_ff[SUM_W-1]};
   assign ge     = (trial >= {1'b0, window_ff});
   assign rem_in = ge ? WIN_W'(trial - {1'b0, window_ff}) : trial[WIN_W-1:0];
   assign dvd_in = {dvd_ff[SUM_W-2:0], ge};

   assign quot_signed = neg_ff ? (~dvd_ff + 1'b1) : dvd_ff;
   assign avg_in      = quot_signed[SAMPLE_W-1:0];

   assign sts.div_last = (cnt_ff == '0);
   assign average      = avg_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= mem[pos_ff];
      end
      if (cmd.update) begin
         mem[pos_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= clamp_window(WIN_W'(WINDOW_RESET), MAX_WINDOW);
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= '0;
      end else if (cmd.cfg_write) begin
         window_ff  <= clamp_window(csr_wdata, MAX_WINDOW);
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= '0;
      end else if (cmd.update) begin
         pos_ff     <= pos_in;
         wrapped_ff <= wrapped_ff | pos_wrap;
         sum_ff     <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= sample;
      end
      if (cmd.div_load) begin
         neg_ff <= sum_ff[SUM_W-1];
         dvd_ff <= sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
         rem_ff <= '0;
         cnt_ff <= CNT_W'(SUM_W - 1);
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.out_load) begin
         avg_ff <= avg_in;
      end
   end

endmodule

FILE: hw/rtl/moving_average_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter unit
// Circular window of signed samples with a running sum; each item yields the
// window mean, truncated toward zero.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-----------------------------
//   req_     | in  | req_tvalid/req_tready  | req_tdata[15:0]  sample
//   rsp_     | out | rsp_tvalid/rsp_tready  | rsp_tdata[15:0]  average
//   csr_     | in  | csr_valid/csr_ready    | csr_wdata[5:0]   window_size
//
// Each item goes from accept to result valid through capture, window update,
// divider load, SUM_W divide steps of one quotient bit each over the running
// sum (21 bits at the default MAX_WINDOW of 32), and the hand-off; the
// bit-serial divider dominates.
// One item is in work at a time; the next item is accepted the cycle after
// the previous result has moved into the output register, so a new item is
// never taken before the last one is through.
// A stalled result holds in the output register until rsp_tready; a second
// finished result then waits in the controller and holds the input off.
// Reset (synchronous) clears the window, the sum and sets window_size to 16;
// both readies stay low while it is applied. A window_size write restarts
// the window the same way. No clearing pass.
// ----------------------------------------------------------------------------
module moving_average_filter_unit
   import mavg_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // [15:0] sample
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,   // [15:0] average
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WIN_W-1:0]    csr_wdata    // [5:0] window_size
);

   mavg_cmd_type               cmd;
   mavg_sts_type               sts;
   logic signed [SAMPLE_W-1:0] average;

   // Sequence the item: capture, update window, divide, hand off.
   mavg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Window memory, running sum and divider.
   mavg_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_wdata (csr_wdata),
      .sample    (req_tdata),
      .average   (average)
   );

   assign rsp_tdata = average;

endmodule
